[hw/rtl/periodic_timer_queue_macros.svh]
// assertion macros used by the timer queue checker
`ifndef PERIODIC_TIMER_QUEUE_MACROS_SVH
`define PERIODIC_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PTQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ptq_pkg.sv]
// shared types, sizes and codes of the periodic timer queue
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int HANDLE_COUNT = 16;
  localparam int HANDLE_W     = 4;
  localparam int CAPACITY     = (QUEUE_DEPTH < HANDLE_COUNT) ? QUEUE_DEPTH : HANDLE_COUNT;
  localparam int RING_DEPTH   = HANDLE_COUNT;
  localparam int RING_W       = $clog2(RING_DEPTH);
  localparam int COUNT_W      = $clog2(RING_DEPTH + 1);
  localparam int TIME_W       = 32;
  localparam int PERIOD_W     = 16;

  // input kinds
  localparam logic [1:0] K_TICK   = 2'd0;
  localparam logic [1:0] K_CREATE = 2'd1;
  localparam logic [1:0] K_DELETE = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_CREATED  = 3'd0;
  localparam logic [2:0] STAT_BAD      = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_DELETED  = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;
  localparam logic [2:0] STAT_FIRED    = 3'd5;
  localparam logic [2:0] STAT_NOTHING  = 3'd6;

  // queue engine commands
  localparam logic [2:0] Q_NOP    = 3'd0;
  localparam logic [2:0] Q_INSERT = 3'd1;
  localparam logic [2:0] Q_DELETE = 3'd2;
  localparam logic [2:0] Q_POP    = 3'd3;
  localparam logic [2:0] Q_FETCH  = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [PERIOD_W-1:0] period;
    logic [HANDLE_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [TIME_W-1:0]   key;     // deadline for insert, current time for pop
    logic [PERIOD_W-1:0] period;
    logic [HANDLE_W-1:0] owner;
    logic [COUNT_W-1:0]  k;       // fired entry to fetch
  } q_cmd_t;

  typedef struct packed {
    logic                done;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  fired;
    logic [PERIOD_W-1:0] period;
    logic [HANDLE_W-1:0] owner;
  } q_resp_t;

  typedef struct packed {
    logic                set_en;
    logic [HANDLE_W-1:0] set_id;
    logic                clr_en;
    logic [HANDLE_W-1:0] clr_id;
  } alloc_ctl_t;

  typedef struct packed {
    logic                free_ok;
    logic [HANDLE_W-1:0] free_id;
    logic                query_used;
  } alloc_stat_t;

endpackage

`default_nettype wire

[hw/rtl/periodic_timer_queue.sv]
// Periodic timer queue: seconds counter plus up to sixteen timers sorted by deadline.
// Input words arrive on s_tvalid/s_tready; s_tuser carries the kind (tick, create,
// delete) and s_tdata the period and the handle. Result words leave on m_tvalid/
// m_tready with the status in m_tuser, handle and seconds count in m_tdata, and
// m_tlast on the final word of an input item.
// One item is in flight at a time; s_tready is high only while the sequencer idles.
// The queue ring is one memory with a registered read; each scan or move step of
// the shared comparator and ring port first sets the read address and then uses
// the read data. A tick pops the due timers, then handles each fired timer in
// turn with a fetch, a result word and a reinsert.
// Results sit in an output register; while m_tready is low the sequencer waits
// at the next word and the held word stays unchanged. A fresh item may be taken
// while the final word of the previous one still waits in that register.
// Synchronous reset clears time, the handle flags, the queue count and the
// output valid flag; the ring memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_queue import ptq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // period[15:0], handle[19:16], zero pad
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // timer_id[3:0], fire_time[35:4], zero pad
  output logic [2:0]       m_tuser,   // status[2:0]
  output logic             m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [1:0] P_POP   = 2'd0;
  localparam logic [1:0] P_FETCH = 2'd1;
  localparam logic [1:0] P_INS   = 2'd2;

  logic [1:0]          state;
  logic [1:0]          tphase;
  logic [1:0]          kind_q;
  logic [TIME_W-1:0]   now;
  logic [COUNT_W-1:0]  n_q;
  logic [COUNT_W-1:0]  k_q;
  logic [PERIOD_W-1:0] per_q;
  logic [HANDLE_W-1:0] own_q;
  logic [2:0]          res_status;
  logic [HANDLE_W-1:0] res_id;
  logic                res_last;
  logic [2:0]          out_status;
  logic [HANDLE_W-1:0] out_id;
  logic [TIME_W-1:0]   out_time;
  logic                out_last;
  logic                out_valid;
  q_cmd_t              cmd;
  q_resp_t             resp;
  alloc_ctl_t          actl;
  alloc_stat_t         astat;

  logic                accept;
  logic [1:0]          in_kind;
  logic [PERIOD_W-1:0] in_period;
  logic [HANDLE_W-1:0] in_handle;
  logic [TIME_W-1:0]   now_inc;
  logic [TIME_W:0]     sum_in;
  logic [TIME_W:0]     sum_q;
  logic [TIME_W-1:0]   dl_in;
  logic [TIME_W-1:0]   dl_q;
  logic                q_full;
  logic                can_create;
  logic [COUNT_W-1:0]  k_inc;
  logic                out_free;

  assign in_kind   = s_tuser;
  assign in_period = s_tdata[PERIOD_W-1:0];
  assign in_handle = s_tdata[PERIOD_W +: HANDLE_W];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign k_inc     = k_q + COUNT_W'(1);

  // saturating time arithmetic
  assign now_inc = (now == '1) ? now : now + TIME_W'(1);
  assign sum_in  = {1'b0, now} + (TIME_W + 1)'(in_period);
  assign sum_q   = {1'b0, now} + (TIME_W + 1)'(per_q);
  assign dl_in   = sum_in[TIME_W] ? '1 : sum_in[TIME_W-1:0];
  assign dl_q    = sum_q[TIME_W] ? '1 : sum_q[TIME_W-1:0];

  assign q_full     = resp.count >= COUNT_W'(CAPACITY);
  assign can_create = (in_period != '0) && !q_full && astat.free_ok;

  assign actl.set_en = accept && (in_kind == K_CREATE) && can_create;
  assign actl.set_id = astat.free_id;
  assign actl.clr_en = accept && (in_kind == K_DELETE) && astat.query_used;
  assign actl.clr_id = in_handle;

  ptq_alloc u_alloc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (actl),
    .query_id (in_handle),
    .stat     (astat)
  );

  ptq_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .resp (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tphase    <= P_POP;
      now       <= '0;
      cmd.op    <= Q_NOP;
      out_valid <= 1'b0;
    end else begin
      cmd.op <= Q_NOP;
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            kind_q <= in_kind;
            tphase <= P_POP;
            case (in_kind)
              K_TICK: begin
                now     <= now_inc;
                cmd.op  <= Q_POP;
                cmd.key <= now_inc;
                state   <= ST_WAIT;
              end
              K_CREATE: begin
                res_last <= 1'b1;
                if (in_period == '0) begin
                  res_status <= STAT_BAD;
                  res_id     <= '0;
                  state      <= ST_OUT;
                end else if (!can_create) begin
                  res_status <= STAT_FULL;
                  res_id     <= '0;
                  state      <= ST_OUT;
                end else begin
                  cmd.op     <= Q_INSERT;
                  cmd.key    <= dl_in;
                  cmd.period <= in_period;
                  cmd.owner  <= astat.free_id;
                  res_status <= STAT_CREATED;
                  res_id     <= astat.free_id;
                  state      <= ST_WAIT;
                end
              end
              K_DELETE: begin
                res_last <= 1'b1;
                res_id   <= in_handle;
                if (astat.query_used) begin
                  cmd.op     <= Q_DELETE;
                  cmd.owner  <= in_handle;
                  res_status <= STAT_DELETED;
                  state      <= ST_WAIT;
                end else begin
                  res_status <= STAT_NOTFOUND;
                  state      <= ST_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WAIT: begin
          if (resp.done) begin
            if (kind_q != K_TICK) begin
              state <= ST_OUT;
            end else begin
              case (tphase)
                P_POP: begin
                  n_q <= resp.fired;
                  if (resp.fired == '0) begin
                    res_status <= STAT_NOTHING;
                    res_id     <= '0;
                    res_last   <= 1'b1;
                    state      <= ST_OUT;
                  end else begin
                    k_q    <= '0;
                    cmd.op <= Q_FETCH;
                    cmd.k  <= '0;
                    tphase <= P_FETCH;
                  end
                end
                P_FETCH: begin
                  per_q      <= resp.period;
                  own_q      <= resp.owner;
                  res_status <= STAT_FIRED;
                  res_id     <= resp.owner;
                  res_last   <= (k_inc == n_q);
                  state      <= ST_OUT;
                end
                default: begin
                  // reinsert finished, move on to the next fired timer
                  k_q <= k_inc;
                  if (k_inc == n_q) begin
                    state <= ST_IDLE;
                  end else begin
                    cmd.op <= Q_FETCH;
                    cmd.k  <= k_inc;
                    tphase <= P_FETCH;
                  end
                end
              endcase
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_id     <= res_id;
            out_time   <= now;
            out_last   <= res_last;
            if (kind_q == K_TICK && tphase == P_FETCH) begin
              cmd.op     <= Q_INSERT;
              cmd.key    <= dl_q;
              cmd.period <= per_q;
              cmd.owner  <= own_q;
              tphase     <= P_INS;
              state      <= ST_WAIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_time, out_id};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

[hw/rtl/ptq_alloc.sv]
// handle allocator: in-use flags and lowest free handle search
`timescale 1ns / 1ps
`default_nettype none

module ptq_alloc import ptq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire alloc_ctl_t          ctl,
  input  wire logic [HANDLE_W-1:0] query_id,
  output alloc_stat_t              stat
);

  logic [HANDLE_COUNT-1:0] in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (ctl.set_en) begin
        in_use[ctl.set_id] <= 1'b1;
      end
      if (ctl.clr_en) begin
        in_use[ctl.clr_id] <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.free_ok    = 1'b0;
    stat.free_id    = '0;
    stat.query_used = in_use[query_id];
    // walk down so the lowest free handle wins
    for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        stat.free_ok = 1'b1;
        stat.free_id = HANDLE_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ptq_queue.sv]
// sorted deadline ring: one memory, one shared deadline comparator, small sequencer
`timescale 1ns / 1ps
`default_nettype none

module ptq_queue import ptq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire q_cmd_t cmd,
  output q_resp_t     resp
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_SCAN = 3'd1;
  localparam logic [2:0] S_INS_SHIFT = 3'd2;
  localparam logic [2:0] S_DEL_SCAN = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_POP      = 3'd5;
  localparam logic [2:0] S_FETCH    = 3'd6;

  logic [2:0]          state;
  logic                ph;
  logic [RING_W-1:0]   head;
  logic [RING_W-1:0]   fire_base;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  idx;
  logic [COUNT_W-1:0]  pos;
  logic [COUNT_W-1:0]  fired;
  logic [TIME_W-1:0]   key;
  entry_t              ent;
  logic                done;
  logic [PERIOD_W-1:0] res_period;
  logic [HANDLE_W-1:0] res_owner;

  entry_t              mem [RING_DEPTH];
  entry_t              rd_data;
  logic [RING_W-1:0]   rd_addr;
  logic [COUNT_W-1:0]  rd_off;
  logic                wr_en;
  logic [RING_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic                lt;
  logic [COUNT_W-1:0]  idx_inc;
  logic [COUNT_W-1:0]  idx_dec;

  assign idx_inc = idx + COUNT_W'(1);
  assign idx_dec = idx - COUNT_W'(1);

  // the one deadline comparator, shared by insert scan and pop
  assign lt = rd_data.deadline < key;

  always_comb begin
    unique case (state)
      S_INS_SHIFT: rd_off = idx_dec;
      S_DEL_SHIFT: rd_off = idx_inc;
      S_POP:       rd_off = '0;
      default:     rd_off = idx;
    endcase
    if (state == S_FETCH) begin
      rd_addr = fire_base + idx[RING_W-1:0];
    end else begin
      rd_addr = head + rd_off[RING_W-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head + idx[RING_W-1:0];
    wr_data = rd_data;
    if (state == S_INS_SHIFT) begin
      if (!ph && idx == pos) begin
        wr_en   = 1'b1;
        wr_addr = head + pos[RING_W-1:0];
        wr_data = ent;
      end else if (ph) begin
        wr_en = 1'b1;
      end
    end else if (state == S_DEL_SHIFT && ph) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= 1'b0;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          ph <= 1'b0;
          case (cmd.op)
            Q_INSERT: begin
              key   <= cmd.key;
              ent   <= '{deadline: cmd.key, period: cmd.period, owner: cmd.owner};
              idx   <= '0;
              state <= S_INS_SCAN;
            end
            Q_DELETE: begin
              ent.owner <= cmd.owner;
              idx       <= '0;
              state     <= S_DEL_SCAN;
            end
            Q_POP: begin
              key       <= cmd.key;
              fire_base <= head;
              fired     <= '0;
              state     <= S_POP;
            end
            Q_FETCH: begin
              idx   <= cmd.k;
              state <= S_FETCH;
            end
            default: ;
          endcase
        end
        S_INS_SCAN: begin
          if (!ph) begin
            if (idx == count) begin
              pos   <= idx;
              state <= S_INS_SHIFT;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph <= 1'b0;
            // equal deadlines: the new entry goes ahead of them
            if (lt) begin
              idx <= idx_inc;
            end else begin
              pos   <= idx;
              idx   <= count;
              state <= S_INS_SHIFT;
            end
          end
        end
        S_INS_SHIFT: begin
          if (!ph) begin
            if (idx == pos) begin
              count <= count + COUNT_W'(1);
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph  <= 1'b0;
            idx <= idx_dec;
          end
        end
        S_DEL_SCAN: begin
          if (!ph) begin
            if (idx == count) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph <= 1'b0;
            if (rd_data.owner == ent.owner) begin
              state <= S_DEL_SHIFT;
            end else begin
              idx <= idx_inc;
            end
          end
        end
        S_DEL_SHIFT: begin
          if (!ph) begin
            if (idx_inc == count) begin
              count <= count - COUNT_W'(1);
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph  <= 1'b0;
            idx <= idx_inc;
          end
        end
        S_POP: begin
          if (!ph) begin
            if (count == '0) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph <= 1'b0;
            // popped entries stay in the ring behind head until refetched
            if (lt) begin
              head  <= head + RING_W'(1);
              count <= count - COUNT_W'(1);
              fired <= fired + COUNT_W'(1);
            end else begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          end
        end
        S_FETCH: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph         <= 1'b0;
            res_period <= rd_data.period;
            res_owner  <= rd_data.owner;
            state      <= S_IDLE;
            done       <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign resp.done   = done;
  assign resp.count  = count;
  assign resp.fired  = fired;
  assign resp.period = res_period;
  assign resp.owner  = res_owner;

endmodule

`default_nettype wire

[hw/rtl/ptq_checker.sv]
// port-level checker for the periodic timer queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_timer_queue_macros.svh"

module ptq_checker import ptq_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  logic [43:0] m_word;
  logic [31:0] t_now;
  logic        hs;
  logic        stall_out;

  assign m_word    = {m_tlast, m_tuser, m_tdata};
  assign t_now     = m_tdata[35:4];
  assign hs        = m_tvalid && m_tready;
  assign stall_out = m_tvalid && !m_tready;

  // a stalled result word holds
  `PTQ_ASSERT_NEXT(a_out_hold, stall_out, m_tvalid && $stable(m_word), "held word changed")

  // only a fired timer word can leave more words of the same item to come
  `PTQ_ASSERT_IMPL(a_single_last, m_tvalid && m_tuser != STAT_FIRED, m_tlast, "missing last")

  // while a burst of fired words is unfinished no new item is taken
  `PTQ_ASSERT_IMPL(a_busy_burst, m_tvalid && !m_tlast, !s_tready, "input taken mid burst")

  // the seconds count in results never goes backwards
  `PTQ_ASSERT_NEXT(a_time_mono, hs, !m_tvalid || t_now >= $past(t_now), "time went back")

endmodule

bind periodic_timer_queue ptq_checker u_ptq_checker (.*);

`default_nettype wire

[tb/tb_periodic_timer_queue.sv]
// self-checking testbench for the periodic timer queue with its own timer predictor
`timescale 1ns / 1ps

module tb_periodic_timer_queue;
  import ptq_pkg::*;

  localparam logic [1:0] K_UNUSED  = 2'd3;   // ignored by the block
  localparam int         MAX_GAP   = 16;
  localparam int         SETTLE    = 200;
  localparam int         CYCLE_CAP = 1_500_000;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  timer_id;
    logic [31:0] fire_time;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // period[15:0], handle[19:16], zero pad
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // timer_id[3:0], fire_time[35:4], zero pad
  logic [2:0]  m_tuser;        // status[2:0]
  logic        m_tlast;

  // predicted timer state
  logic [31:0]         now_sec;
  logic [TIME_W-1:0]   slot_dl  [QUEUE_DEPTH];
  logic [PERIOD_W-1:0] slot_per [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] slot_own [QUEUE_DEPTH];
  int                  slot_cnt;
  logic                handle_busy [HANDLE_COUNT];

  timer_result_t expected_results[$];
  int            fail_count   = 0;
  int            cycle_count  = 0;
  int            src_max_gap  = MAX_GAP;
  int            sink_max_gap = MAX_GAP;
  int            sink_hold    = 0;

  periodic_timer_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void push_result(logic [2:0] st, logic [3:0] id, logic last);
    timer_result_t r;
    r.status    = st;
    r.timer_id  = id;
    r.fire_time = now_sec;
    r.last      = last;
    expected_results = {expected_results, r};
  endfunction

  // new timer leaves ahead of any timer with an equal deadline
  function automatic void place_timer(logic [31:0] dl, logic [15:0] per, logic [3:0] own);
    int p;
    p = 0;
    if (slot_cnt >= CAPACITY) return;
    while (p < slot_cnt && slot_dl[p] < dl) p++;
    for (int i = slot_cnt; i > p; i--) begin
      slot_dl[i]  = slot_dl[i-1];
      slot_per[i] = slot_per[i-1];
      slot_own[i] = slot_own[i-1];
    end
    slot_dl[p]  = dl;
    slot_per[p] = per;
    slot_own[p] = own;
    slot_cnt++;
  endfunction

  function automatic void drop_timer(int p);
    for (int i = p; i + 1 < slot_cnt; i++) begin
      slot_dl[i]  = slot_dl[i+1];
      slot_per[i] = slot_per[i+1];
      slot_own[i] = slot_own[i+1];
    end
    slot_cnt--;
  endfunction

  function automatic void clear_timers();
    now_sec  = '0;
    slot_cnt = 0;
    foreach (handle_busy[h]) handle_busy[h] = 1'b0;
  endfunction

  function automatic void predict_timer_item(logic [1:0] kind, logic [15:0] per,
                                             logic [3:0] hnd);
    logic [15:0] fired_per [HANDLE_COUNT];
    logic [3:0]  fired_own [HANDLE_COUNT];
    int          n;
    int          h;
    n = 0;
    h = 0;
    case (kind)
      K_TICK: begin
        now_sec = sat_sum(now_sec, 32'd1);
        while (slot_cnt > 0 && n < HANDLE_COUNT && now_sec > slot_dl[0]) begin
          fired_per[n] = slot_per[0];
          fired_own[n] = slot_own[0];
          n++;
          drop_timer(0);
        end
        if (n == 0) push_result(STAT_NOTHING, 4'd0, 1'b1);
        for (int k = 0; k < n; k++) begin
          push_result(STAT_FIRED, fired_own[k], k == n - 1);
          place_timer(sat_sum(now_sec, {16'd0, fired_per[k]}), fired_per[k], fired_own[k]);
        end
      end
      K_CREATE: begin
        while (h < HANDLE_COUNT && handle_busy[h]) h++;
        if (per == '0) begin
          push_result(STAT_BAD, 4'd0, 1'b1);
        end else if (slot_cnt >= CAPACITY || h >= HANDLE_COUNT) begin
          push_result(STAT_FULL, 4'd0, 1'b1);
        end else begin
          handle_busy[h] = 1'b1;
          place_timer(sat_sum(now_sec, {16'd0, per}), per, h[3:0]);
          push_result(STAT_CREATED, h[3:0], 1'b1);
        end
      end
      K_DELETE: begin
        if (handle_busy[hnd]) begin
          for (int p = 0; p < slot_cnt; p++) begin
            if (slot_own[p] == hnd) begin
              drop_timer(p);
              break;
            end
          end
          handle_busy[hnd] = 1'b0;
          push_result(STAT_DELETED, hnd, 1'b1);
        end else begin
          push_result(STAT_NOTFOUND, hnd, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // offer one input word after a random gap; valid stays high if the next gap is zero
  task automatic send_item(logic [1:0] kind, logic [15:0] per, logic [3:0] hnd);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, hnd, per};
    do @(posedge clk); while (!s_tready);
    predict_timer_item(kind, per, hnd);
  endtask

  task automatic send_random_item();
    int          roll;
    logic [1:0]  kind;
    logic [15:0] per;
    logic [3:0]  hnd;
    int          busy_list[$];
    roll = $urandom_range(0, 99);
    per  = 16'($urandom);
    hnd  = 4'($urandom);
    if (roll < 40) begin
      kind = K_TICK;
    end else if (roll < 72) begin
      kind = K_CREATE;
      roll = $urandom_range(0, 9);
      if (roll < 8) per = 16'($urandom_range(1, 6));
      else if (roll == 8) per = '0;
    end else if (roll < 96) begin
      kind = K_DELETE;
      foreach (handle_busy[h]) if (handle_busy[h]) busy_list = {busy_list, h};
      if (busy_list.size() > 0 && $urandom_range(0, 3) != 0)
        hnd = 4'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
    end else begin
      kind = K_UNUSED;
    end
    send_item(kind, per, hnd);
  endtask

  task automatic test_basic_ops();
    send_item(K_TICK, 16'h0000, 4'h0);      // nothing due
    send_item(K_CREATE, 16'h0000, 4'hF);    // zero period rejected
    send_item(K_CREATE, 16'h0001, 4'h0);
    send_item(K_CREATE, 16'h0001, 4'h0);    // equal deadline, leaves first
    send_item(K_CREATE, 16'hFFFF, 4'h0);
    send_item(K_UNUSED, 16'hFFFF, 4'hF);
    send_item(K_DELETE, 16'hFFFF, 4'hF);    // unknown handle
    send_item(K_TICK, 16'hFFFF, 4'hF);
    send_item(K_TICK, 16'h0000, 4'h0);      // both short timers fire
    send_item(K_DELETE, 16'h0000, 4'h2);
    send_item(K_DELETE, 16'h0000, 4'h2);
  endtask

  task automatic test_full_queue();
    send_item(K_DELETE, 16'h0000, 4'h0);
    send_item(K_DELETE, 16'h0000, 4'h1);
    for (int i = 0; i < CAPACITY; i++) send_item(K_CREATE, 16'h0001, 4'h0);
    send_item(K_CREATE, 16'h0001, 4'h0);    // no room left
    send_item(K_TICK, 16'h0000, 4'h0);
    send_item(K_TICK, 16'h0000, 4'h0);      // all sixteen fire in one tick
  endtask

  task automatic test_random_traffic(int n_items, int src_gap, int sink_gap);
    src_max_gap  = src_gap;
    sink_max_gap = sink_gap;
    for (int i = 0; i < n_items; i++) send_random_item();
  endtask

  task automatic test_backpressure();
    src_max_gap  = 0;
    sink_max_gap = 2;
    sink_hold    = 400;
    for (int i = 0; i < 40; i++) send_random_item();
    sink_max_gap = MAX_GAP;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result consumer: random stalls, plus one long hold when asked
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      stall = $urandom_range(0, sink_max_gap);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      timer_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result word: status %0d timer_id %0d", m_tuser, m_tdata[3:0]);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[3:0] !== exp_r.timer_id) begin
          $error("timer_id: expected %0d, got %0d", exp_r.timer_id, m_tdata[3:0]);
          fail_count++;
        end
        if (m_tdata[35:4] !== exp_r.fire_time) begin
          $error("fire_time: expected %0d, got %0d", exp_r.fire_time, m_tdata[35:4]);
          fail_count++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clear_timers();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_full_queue();
    test_random_traffic(50, MAX_GAP, MAX_GAP);
    test_random_traffic(60, 0, 0);
    test_backpressure();
    test_random_traffic(30, MAX_GAP, 0);
    drain_results();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[periodic_timer_queue.f]
+incdir+hw/rtl
hw/rtl/ptq_pkg.sv
hw/rtl/ptq_alloc.sv
hw/rtl/ptq_queue.sv
hw/rtl/periodic_timer_queue.sv
hw/rtl/ptq_checker.sv
tb/tb_periodic_timer_queue.sv
